// ===== hdl/ulv_pkg.sv =====
package ulv_pkg;

   // field widths
   localparam int BYTE_W   = 8;
   localparam int CP_W     = 21;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 13;
   localparam int MAX_W    = 12;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_UTF8   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CONTROL    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EDGE_SPACE = 3'd5;

   // event kinds passed from decoder to checker
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_POINT = 2'd1;
   localparam logic [1:0] EV_BAD   = 2'd2;

   // reset value of the length limit
   localparam logic [MAX_W-1:0] MAX_CHARS_RESET = 12'd200;

   // code point bounds
   localparam logic [CP_W-1:0] CP_MAX     = 21'h10ffff;
   localparam logic [CP_W-1:0] CP_SURR_LO = 21'h00d800;
   localparam logic [CP_W-1:0] CP_SURR_HI = 21'h00dfff;
   localparam logic [CP_W-1:0] CP_MIN_2   = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_3   = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_4   = 21'h010000;

   // one decoded request as it sits in the queue
   typedef struct packed {
      logic [1:0]      kind;
      logic [CP_W-1:0] cp;
      logic            last;
      logic            empty;
   } ulv_event_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic not_empty;
   } ulv_qstat_type;

endpackage

// ===== hdl/ulv_req_if.sv =====
interface ulv_req_if import ulv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_label;
   logic              empty_mark;

   modport source (output valid, data_byte, end_of_label, empty_mark, input ready);
   modport sink   (input valid, data_byte, end_of_label, empty_mark, output ready);
endinterface

// ===== hdl/ulv_rsp_if.sv =====
interface ulv_rsp_if import ulv_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  char_count;

   modport source (output valid, status, char_count, input ready);
   modport sink   (input valid, status, char_count, output ready);
endinterface

// ===== hdl/ulv_front.sv =====
module ulv_front import ulv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ulv_req_if.sink       req,
   input  ulv_qstat_type qstat,
   output logic          push,
   output ulv_event_type push_event
);

   logic [1:0]      pend_ff, pend_in;
   logic [1:0]      seq_ff, seq_in;
   logic [CP_W-1:0] part_ff, part_in;
   logic            err_ff, err_in;

   logic [BYTE_W-1:0] b;
   logic [1:0]        pend_dec;
   logic [CP_W-1:0]   part_shift;
   logic [1:0]        kind;
   logic [CP_W-1:0]   cp;
   logic              overlong;

   assign req.ready = ~qstat.full;
   assign push      = req.valid & ~qstat.full;
   assign b         = req.data_byte;
   assign pend_dec  = pend_ff - 2'd1;
   assign part_shift = {part_ff[CP_W-7:0], b[5:0]};

   // sequence length specific lower bounds
   always_comb begin
      case (seq_ff)
         2'd1:    overlong = part_shift < CP_MIN_2;
         2'd2:    overlong = part_shift < CP_MIN_3;
         2'd3:    overlong = part_shift < CP_MIN_4;
         default: overlong = 1'b0;
      endcase
   end

   // byte decoder
   always_comb begin
      pend_in = pend_ff;
      seq_in  = seq_ff;
      part_in = part_ff;
      err_in  = err_ff;
      kind    = EV_NONE;
      cp      = part_shift;
      if (!err_ff && !req.empty_mark) begin
         if (pend_ff == 2'd0) begin
            if (!b[7]) begin
               kind = EV_POINT;
               cp   = CP_W'(b);
            end else if (b[7:5] == 3'b110) begin
               seq_in  = 2'd1;
               pend_in = 2'd1;
               part_in = CP_W'(b[4:0]);
            end else if (b[7:4] == 4'b1110) begin
               seq_in  = 2'd2;
               pend_in = 2'd2;
               part_in = CP_W'(b[3:0]);
            end else if (b[7:3] == 5'b11110) begin
               seq_in  = 2'd3;
               pend_in = 2'd3;
               part_in = CP_W'(b[2:0]);
            end else begin
               kind = EV_BAD;
            end
         end else if (b[7:6] != 2'b10) begin
            kind = EV_BAD;
         end else begin
            pend_in = pend_dec;
            part_in = part_shift;
            if (pend_dec == 2'd0) begin
               part_in = '0;
               seq_in  = 2'd0;
               if (overlong || part_shift > CP_MAX ||
                   (part_shift >= CP_SURR_LO && part_shift <= CP_SURR_HI)) begin
                  kind = EV_BAD;
               end else begin
                  kind = EV_POINT;
               end
            end
         end
         // sequence still open at the end of the label
         if (req.end_of_label && kind != EV_BAD && pend_in != 2'd0) begin
            kind = EV_BAD;
         end
         if (kind == EV_BAD) begin
            err_in = 1'b1;
         end
      end
      if (req.empty_mark || req.end_of_label) begin
         pend_in = 2'd0;
         seq_in  = 2'd0;
         part_in = '0;
         err_in  = 1'b0;
      end
   end

   // event to the queue
   always_comb begin
      push_event.kind  = kind;
      push_event.cp    = cp;
      push_event.last  = req.end_of_label;
      push_event.empty = req.empty_mark;
   end

   // decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
         seq_ff  <= 2'd0;
         part_ff <= '0;
         err_ff  <= 1'b0;
      end else if (push) begin
         pend_ff <= pend_in;
         seq_ff  <= seq_in;
         part_ff <= part_in;
         err_ff  <= err_in;
      end
   end

endmodule

// ===== hdl/ulv_queue.sv =====
module ulv_queue import ulv_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  ulv_event_type push_event,
   input  logic          pop,
   output ulv_event_type pop_event,
   output ulv_qstat_type qstat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   ulv_event_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign qstat.full      = cnt_ff == CNT_FULL;
   assign qstat.not_empty = cnt_ff != '0;
   assign pop_event       = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule

// ===== hdl/ulv_back.sv =====
module ulv_back import ulv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [MAX_W-1:0] max_chars,
   input  ulv_qstat_type    qstat,
   input  ulv_event_type    pop_event,
   output logic             pop,
   ulv_rsp_if.source        rsp
);

   function automatic logic is_space(input logic [CP_W-1:0] v);
      return (v >= 21'h0009 && v <= 21'h000d) || v == 21'h0020 || v == 21'h0085 ||
             v == 21'h00a0 || v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200a) ||
             v == 21'h2028 || v == 21'h2029 || v == 21'h202f || v == 21'h205f ||
             v == 21'h3000;
   endfunction

   function automatic logic is_control(input logic [CP_W-1:0] v);
      return v <= 21'h001f || (v >= 21'h007f && v <= 21'h009f) ||
             v == 21'h2028 || v == 21'h2029;
   endfunction

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                fs_ff, fs_in;
   logic                ls_ff, ls_in;
   logic [STATUS_W-1:0] err_ff, err_in;

   logic                out_valid_ff;
   logic [STATUS_W-1:0] out_status_ff, res_status;
   logic [COUNT_W-1:0]  out_count_ff, res_count;

   logic has_result;
   logic sp;

   assign has_result = pop_event.empty | pop_event.last;
   assign pop = qstat.not_empty & (~has_result | ~out_valid_ff | rsp.ready);
   assign sp  = is_space(pop_event.cp);

   assign rsp.valid      = out_valid_ff;
   assign rsp.status     = out_status_ff;
   assign rsp.char_count = out_count_ff;

   // code point checks and label result
   always_comb begin
      count_in   = count_ff;
      fs_in      = fs_ff;
      ls_in      = ls_ff;
      err_in     = err_ff;
      res_status = ST_EMPTY;
      res_count  = '0;
      if (!pop_event.empty) begin
         if (err_ff == ST_OK) begin
            case (pop_event.kind)
               EV_POINT: begin
                  if (is_control(pop_event.cp)) begin
                     err_in = ST_CONTROL;
                  end else begin
                     if (count_ff == '0) begin
                        fs_in = sp;
                     end
                     ls_in    = sp;
                     count_in = count_ff + 1'b1;
                     if (count_in > COUNT_W'(max_chars)) begin
                        err_in = ST_TOO_LONG;
                     end
                  end
               end
               EV_BAD:  err_in = ST_BAD_UTF8;
               default: err_in = err_ff;
            endcase
         end
         if (err_in != ST_OK) begin
            res_status = err_in;
         end else if (fs_in || ls_in) begin
            res_status = ST_EDGE_SPACE;
         end else begin
            res_status = ST_OK;
         end
         res_count = count_in;
      end
      if (has_result) begin
         count_in = '0;
         fs_in    = 1'b0;
         ls_in    = 1'b0;
         err_in   = ST_OK;
      end
   end

   // label state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fs_ff    <= 1'b0;
         ls_ff    <= 1'b0;
         err_ff   <= ST_OK;
      end else if (pop) begin
         count_ff <= count_in;
         fs_ff    <= fs_in;
         ls_ff    <= ls_in;
         err_ff   <= err_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (pop && has_result) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && has_result) begin
         out_status_ff <= res_status;
         out_count_ff  <= res_count;
      end
   end

endmodule

// ===== hdl/utf8_label_validator.sv =====
// UTF-8 label validator
// The req channel takes one label byte per request, with end_of_label on
// the final byte; a request with empty_mark set stands for a whole empty
// label. The rsp channel gives one status and code point count per label,
// on the request that ends it or on an empty mark.
// csr_wr_en/csr_wr_data set max_chars; write only while the block is idle.
// A decoder accepts bytes and builds code points; a queue of QUEUE_DEPTH
// entries carries them to a checker that applies the control, length and
// whitespace rules and holds the result in an output register.
// Throughput: one request per cycle while the queue is not full. The request
// that ends a label is written into the queue, then its result is held in
// the checker's output register.
// Reset clears all label state, empties the queue, drops any pending result
// and sets max_chars to 200.
// When rsp_ready is low the result is held; requests keep flowing into the
// queue until it fills, then req ready drops until the result is taken.
module utf8_label_validator import ulv_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   ulv_req_if.sink          req_bus,
   ulv_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic [MAX_W-1:0] csr_wr_data
);

   logic [MAX_W-1:0] max_chars_ff;
   logic             push;
   logic             pop;
   ulv_event_type    push_event;
   ulv_event_type    pop_event;
   ulv_qstat_type    qstat;

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else if (csr_wr_en) begin
         max_chars_ff <= csr_wr_data;
      end
   end

   ulv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .qstat      (qstat),
      .push       (push),
      .push_event (push_event)
   );

   ulv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .pop_event  (pop_event),
      .qstat      (qstat)
   );

   ulv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .max_chars (max_chars_ff),
      .qstat     (qstat),
      .pop_event (pop_event),
      .pop       (pop),
      .rsp       (rsp_bus)
   );

endmodule

// ===== hdl/ulv_checker.sv =====
module ulv_checker import ulv_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] status,
   input logic [COUNT_W-1:0]  char_count
);

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a result waits until taken
   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // only defined status codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> status <= ST_EDGE_SPACE)
      else $error("undefined status code");

   // empty label counts nothing
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ST_EMPTY |-> char_count == '0)
      else $error("empty label with nonzero count");

   // a clean label holds at least one code point
   a_clean_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_OK || status == ST_EDGE_SPACE) |-> char_count != '0)
      else $error("clean label with zero count");

endmodule

bind utf8_label_validator ulv_checker u_ulv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .status     (rsp_bus.status),
   .char_count (rsp_bus.char_count)
);

// ===== verif/tb.sv =====
module tb;
   import ulv_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 7;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD    = 250;
   localparam int PHASE_ITEMS  = 135;
   localparam int PHASES       = 6;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int PLAN_ROWS    = 27;

   // one expected result
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } verdict_type;

   // directed stimulus rows: a request or a limit write
   typedef enum logic {ROW_REQ, ROW_LIMIT} row_kind_type;

   typedef struct packed {
      row_kind_type        kind;
      logic [MAX_W-1:0]    value;
      logic                eol;
      logic                emp;
      logic                typed;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } plan_row_type;

   // whitespace and boundary code points used by the label builder
   localparam logic [CP_W-1:0] BLANK_POINTS [9] = '{
      21'h20, 21'ha0, 21'h1680, 21'h2000, 21'h2005, 21'h200a, 21'h202f, 21'h205f, 21'h3000
   };
   localparam logic [CP_W-1:0] BOUNDARY_POINTS [9] = '{
      21'h7e, 21'ha0, 21'h7ff, 21'h800, 21'hffff, 21'h10000, 21'h10ffff, 21'hd7ff, 21'he000
   };

   // per phase: limit, sender idle odds, receiver stall odds (0 means none)
   localparam logic [MAX_W-1:0] PHASE_LIMIT [PHASES] = '{
      12'd4095, 12'd3, 12'd12, 12'd1, 12'd0, 12'd200
   };
   localparam int SEND_ODDS [PHASES] = '{6, 3, 4, 0, 8, 0};
   localparam int RECV_ODDS [PHASES] = '{5, 4, 0, 3, 6, 0};

   // directed part, typed results where they are obvious
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      '{ROW_REQ,   12'h0ff, 1'b1, 1'b1, 1'b1, ST_EMPTY,      13'd0},
      '{ROW_REQ,   12'h041, 1'b1, 1'b0, 1'b1, ST_OK,         13'd1},
      '{ROW_REQ,   12'h000, 1'b1, 1'b0, 1'b1, ST_CONTROL,    13'd0},
      '{ROW_REQ,   12'h020, 1'b1, 1'b0, 1'b1, ST_EDGE_SPACE, 13'd1},
      '{ROW_REQ,   12'h0ff, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_REQ,   12'h0c3, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h0a9, 1'b1, 1'b0, 1'b1, ST_OK,         13'd1},
      '{ROW_REQ,   12'h0c1, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h0bf, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_REQ,   12'h0ed, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h0a0, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h080, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_REQ,   12'h0f4, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h090, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h080, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h080, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_REQ,   12'h0e2, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_REQ,   12'h041, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h000, 1'b0, 1'b1, 1'b1, ST_EMPTY,      13'd0},
      '{ROW_REQ,   12'h0fe, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h041, 1'b1, 1'b0, 1'b1, ST_BAD_UTF8,   13'd0},
      '{ROW_LIMIT, 12'd0,   1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h041, 1'b1, 1'b0, 1'b1, ST_TOO_LONG,   13'd1},
      '{ROW_LIMIT, 12'd1,   1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h042, 1'b0, 1'b0, 1'b0, ST_OK,         13'd0},
      '{ROW_REQ,   12'h07e, 1'b1, 1'b0, 1'b1, ST_TOO_LONG,   13'd2},
      '{ROW_LIMIT, 12'd4095, 1'b0, 1'b0, 1'b0, ST_OK,        13'd0}
   };

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [MAX_W-1:0] csr_wr_data;

   ulv_req_if req_bus ();
   ulv_rsp_if rsp_bus ();

   utf8_label_validator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // predicted label state
   logic [MAX_W-1:0]    limit_now;
   logic [1:0]          cont_left;
   logic [1:0]          cont_total;
   logic [CP_W-1:0]     cp_acc;
   logic [COUNT_W-1:0]  points;
   logic                lead_space;
   logic                tail_space;
   logic [STATUS_W-1:0] fault;

   verdict_type verdicts_due [$];
   logic [7:0]  label_bytes [$];
   int          mismatches = 0;
   int          sent = 0;
   int          send_idle_odds = 0;
   int          recv_stall_odds = 0;
   bit          hold_off_due = 0;

   function automatic bit is_blank(input logic [CP_W-1:0] v);
      return (v >= 21'h9 && v <= 21'hd) || v == 21'h20 || v == 21'h85 || v == 21'ha0 ||
             v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200a) || v == 21'h2028 ||
             v == 21'h2029 || v == 21'h202f || v == 21'h205f || v == 21'h3000;
   endfunction

   function automatic void clear_label_state();
      cont_left  = '0;
      cont_total = '0;
      cp_acc     = '0;
      points     = '0;
      lead_space = 1'b0;
      tail_space = 1'b0;
      fault      = ST_OK;
   endfunction

   // control and separator rejection, then whitespace flags and the length count
   function automatic void take_point(input logic [CP_W-1:0] v);
      if (v <= 21'h1f || (v >= 21'h7f && v <= 21'h9f) || v == 21'h2028 || v == 21'h2029) begin
         fault = ST_CONTROL;
      end else begin
         if (points == 0) lead_space = is_blank(v);
         tail_space = is_blank(v);
         points = points + 13'd1;
         if (points > {1'b0, limit_now}) fault = ST_TOO_LONG;
      end
   endfunction

   // advance the label state by one request, returns 1 when a result is due
   function automatic bit label_step(input logic [7:0] b, input logic eol, input logic emp,
                                     output verdict_type v);
      logic [CP_W-1:0] cp;
      logic            bad;
      v = '0;
      if (emp) begin
         clear_label_state();
         v.status = ST_EMPTY;
         return 1'b1;
      end
      if (fault == ST_OK) begin
         if (cont_left == 0) begin
            if (!b[7]) take_point({13'd0, b});
            else if (b[7:5] == 3'b110) begin
               cont_total = 2'd1; cont_left = 2'd1; cp_acc = {16'd0, b[4:0]};
            end else if (b[7:4] == 4'b1110) begin
               cont_total = 2'd2; cont_left = 2'd2; cp_acc = {17'd0, b[3:0]};
            end else if (b[7:3] == 5'b11110) begin
               cont_total = 2'd3; cont_left = 2'd3; cp_acc = {18'd0, b[2:0]};
            end else fault = ST_BAD_UTF8;
         end else if (b[7:6] != 2'b10) begin
            fault = ST_BAD_UTF8;
         end else begin
            cp_acc = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 0) begin
               cp = cp_acc;
               bad = (cont_total == 2'd1 && cp < CP_MIN_2) ||
                     (cont_total == 2'd2 && cp < CP_MIN_3) ||
                     (cont_total == 2'd3 && cp < CP_MIN_4) ||
                     cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI);
               cp_acc = '0;
               cont_total = '0;
               if (bad) fault = ST_BAD_UTF8;
               else take_point(cp);
            end
         end
      end
      if (!eol) return 1'b0;
      // a sequence still open at the end is a truncation
      if (fault == ST_OK && cont_left != 0) fault = ST_BAD_UTF8;
      if (fault != ST_OK) v.status = fault;
      else if (lead_space || tail_space) v.status = ST_EDGE_SPACE;
      else v.status = ST_OK;
      v.count = points;
      clear_label_state();
      return 1'b1;
   endfunction

   // encode a code point into label_bytes with a given sequence length
   function automatic void append_point(input logic [CP_W-1:0] cp, input int len);
      case (len)
         1: label_bytes.push_back({1'b0, cp[6:0]});
         2: begin
            label_bytes.push_back({3'b110, cp[10:6]});
            label_bytes.push_back({2'b10, cp[5:0]});
         end
         3: begin
            label_bytes.push_back({4'b1110, cp[15:12]});
            label_bytes.push_back({2'b10, cp[11:6]});
            label_bytes.push_back({2'b10, cp[5:0]});
         end
         default: begin
            label_bytes.push_back({5'b11110, cp[20:18]});
            label_bytes.push_back({2'b10, cp[17:12]});
            label_bytes.push_back({2'b10, cp[11:6]});
            label_bytes.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   // build a label; clean ones hold only well-formed, mostly legal points
   function automatic void build_label(input bit clean);
      int              pts;
      int              kind;
      int              len;
      bit              cut;
      logic [CP_W-1:0] cp;
      label_bytes.delete();
      pts = $urandom_range(1, 12);
      for (int i = 0; i < pts; i++) begin
         kind = clean ? $urandom_range(0, 79) : $urandom_range(0, 99);
         len = 0;
         cut = 1'b0;
         if (kind < 35) cp = CP_W'($urandom_range(21'h21, 21'h7e));
         else if (kind < 45) cp = BLANK_POINTS[$urandom_range(0, 8)];
         else if (kind < 60) cp = CP_W'($urandom_range(21'h80, 21'h7ff));
         else if (kind < 72) cp = CP_W'($urandom_range(21'h800, 21'hffff));
         else if (kind < 80) cp = CP_W'($urandom_range(21'h10000, 21'h10ffff));
         else if (kind < 84) begin
            case ($urandom_range(0, 2))
               0: cp = CP_W'($urandom_range(0, 21'h1f));
               1: cp = CP_W'($urandom_range(21'h7f, 21'h9f));
               default: cp = 21'h2028 + CP_W'($urandom_range(0, 1));
            endcase
         end else if (kind < 87) begin
            // overlong forms
            case ($urandom_range(0, 2))
               0: begin
                  cp = CP_W'($urandom_range(0, 21'h7f)); len = $urandom_range(2, 4);
               end
               1: begin
                  cp = CP_W'($urandom_range(21'h80, 21'h7ff)); len = $urandom_range(3, 4);
               end
               default: begin
                  cp = CP_W'($urandom_range(21'h800, 21'hffff)); len = 4;
               end
            endcase
         end else if (kind < 89) begin
            cp = CP_W'($urandom_range(21'h110000, 21'h1fffff));
            len = 4;
         end else if (kind < 91) cp = CP_W'($urandom_range(21'hd800, 21'hdfff));
         else if (kind < 94) begin
            // stray continuation or impossible lead
            if ($urandom_range(0, 1)) label_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
            else label_bytes.push_back(8'($urandom_range(8'hf8, 8'hff)));
            continue;
         end else if (kind < 97) begin
            cp = CP_W'($urandom_range(21'h80, 21'h10ffff));
            cut = 1'b1;
         end else cp = BOUNDARY_POINTS[$urandom_range(0, 8)];
         if (len == 0) len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
         append_point(cp, len);
         if (cut) repeat ($urandom_range(1, len - 1)) label_bytes.delete(label_bytes.size() - 1);
      end
   endfunction

   // offer one request and hold it until taken, then maybe go idle
   task automatic offer_req(input logic [7:0] b, input logic eol, input logic emp);
      req_bus.valid        <= 1'b1;
      req_bus.data_byte    <= b;
      req_bus.end_of_label <= eol;
      req_bus.empty_mark   <= emp;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      if (send_idle_odds != 0 && $urandom_range(1, send_idle_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_req(input logic [7:0] b, input logic eol, input logic emp);
      verdict_type v;
      if (label_step(b, eol, emp, v)) verdicts_due.push_back(v);
      offer_req(b, eol, emp);
   endtask

   task automatic send_label(input bit close);
      foreach (label_bytes[i])
         send_req(label_bytes[i], close && (i == label_bytes.size() - 1), 1'b0);
   endtask

   // stop sending, wait for every result, then let the pipeline empty
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input logic [MAX_W-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // run limit
   initial begin
      #(CLK_PERIOD * TIMEOUT_CYCLES);
      $display("tb: errors");
      $finish;
   end

   // result receiver with random stalls and one long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_due) begin
            hold_off_due = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (recv_stall_odds != 0 && $urandom_range(1, recv_stall_odds) == 1) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d count %0d",
                     $time, rsp_bus.status, rsp_bus.char_count);
            mismatches++;
         end else begin
            want = verdicts_due.pop_front();
            if (rsp_bus.status !== want.status) begin
               $display("%0t: status expected %0d got %0d", $time, want.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.char_count !== want.count) begin
               $display("%0t: char_count expected %0d got %0d",
                        $time, want.count, rsp_bus.char_count);
               mismatches++;
            end
         end
      end
   end

   // stimulus
   initial begin
      verdict_type v;
      bit          due;
      int          start;
      int          pick;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.data_byte    = '0;
      req_bus.end_of_label = 1'b0;
      req_bus.empty_mark   = 1'b0;
      limit_now = MAX_CHARS_RESET;
      clear_label_state();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_LIMIT) begin
            set_limit(PLAN[i].value);
         end else begin
            due = label_step(PLAN[i].value[7:0], PLAN[i].eol, PLAN[i].emp, v);
            if (PLAN[i].typed) begin
               v.status = PLAN[i].status;
               v.count  = PLAN[i].count;
            end
            if (due || PLAN[i].typed) verdicts_due.push_back(v);
            offer_req(PLAN[i].value[7:0], PLAN[i].eol, PLAN[i].emp);
         end
      end

      // random phases, each under its own limit and idling pattern
      for (int p = 0; p < PHASES; p++) begin
         set_limit(p == 4 ? MAX_W'($urandom_range(1, 4095)) : PHASE_LIMIT[p]);
         send_idle_odds  = SEND_ODDS[p];
         recv_stall_odds = RECV_ODDS[p];
         if (p == 1) hold_off_due = 1'b1;
         start = sent;
         while (sent - start < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               build_label(1'b1);
               send_label(1'b1);
            end else if (pick < 84) begin
               build_label(1'b0);
               send_label(1'b1);
            end else if (pick < 91) begin
               // raw byte noise
               label_bytes.delete();
               repeat ($urandom_range(1, 6)) label_bytes.push_back(8'($urandom_range(0, 255)));
               send_label(1'b1);
            end else if (pick < 96) begin
               send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
               // label cut short by an empty mark
               build_label(1'b1);
               send_label(1'b0);
               send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
         end
      end

      drain_results();
      if (mismatches == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

endmodule
